@@ rtl/pslsched_pkg.sv @@
package pslsched_pkg;

    // operation codes of an input beat
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_SLEEP   = 2'd1,
        OP_TICK    = 2'd2,
        OP_PROMOTE = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_IDLE    = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SLEEP,
        S_TPROC,
        S_TFIX,
        S_PPROC,
        S_HRD,
        S_HWAIT,
        S_OUT
    } state_t;

    localparam int unsigned WORD_W = 32;

endpackage

@@ rtl/pslsched_ram.sv @@
module pslsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/process_slot_list_scheduler_unit.sv @@
// channel | handshake                 | payload
// item    | item_valid / item_stall   | operation, page_dir, sleep_ticks
// result  | result_valid/result_stall | status, slot, task_id, running_slot,
//         |                           | running_id, running_page_dir, woken_count, idle
//
// one beat at a time: each operation runs S_EXEC, S_HRD, S_HWAIT and S_OUT; a granted
// sleep adds S_SLEEP, tick adds S_TPROC per sleeping task and S_TFIX per woken task
// behind a task that stays, promote adds S_PPROC per ready task, and S_IDLE comes
// before the next beat, all set by the single read and write port of the record memory.
// item_stall is high from acceptance until the result beat is taken.
// reset clears the list heads and counters; no memory clearing pass is needed.
module process_slot_list_scheduler_unit #(
    parameter int SLOTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  pslsched_pkg::op_t          operation,
    input  logic [31:0]                page_dir,
    input  logic [31:0]                sleep_ticks,
    output logic                       result_valid,
    input  logic                       result_stall,
    output pslsched_pkg::status_t      status,
    output logic [3:0]                 slot,
    output logic [31:0]                task_id,
    output logic [3:0]                 running_slot,
    output logic [31:0]                running_id,
    output logic [31:0]                running_page_dir,
    output logic [4:0]                 woken_count,
    output logic                       idle
);

    import pslsched_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int RW = 4 * WORD_W + LW;
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [31:0]      pd_reg, pd_next;
    logic [31:0]      st_reg, st_next;
    logic [LW-1:0]    free_reg, free_next;
    logic [LW-1:0]    ready_reg, ready_next;
    logic [LW-1:0]    run_reg, run_next;
    logic [LW-1:0]    sleep_reg, sleep_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    prev_reg, prev_next;
    logic [RW-1:0]    prec_reg, prec_next;
    logic [31:0]      ctr_reg, ctr_next;
    logic [4:0]       woken_reg, woken_next;
    status_t          status_reg, status_next;
    logic [LW-1:0]    slot_reg, slot_next;
    logic [31:0]      tid_reg, tid_next;
    logic [3:0]       rslot_reg, rslot_next;
    logic [31:0]      rid_reg, rid_next;
    logic [31:0]      rpd_reg, rpd_next;
    logic             idle_reg, idle_next;

    logic             we;
    logic [SW-1:0]    waddr, raddr;
    logic [RW-1:0]    wdata, rdata;

    logic [31:0]      r_id, r_pd, r_cnt, r_lim, cnt_inc;
    logic [LW-1:0]    r_link;
    logic             wake;

    pslsched_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_rec (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // record fields: id, page dir, tick count, sleep limit, link
    assign r_id    = rdata[RW-1 -: 32];
    assign r_pd    = rdata[RW-33 -: 32];
    assign r_cnt   = rdata[RW-65 -: 32];
    assign r_lim   = rdata[RW-97 -: 32];
    assign r_link  = rdata[LW-1:0];
    assign cnt_inc = r_cnt + 32'd1;
    assign wake    = (cnt_inc == r_lim);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_ALLOC:   state_next = S_HRD;
                    OP_SLEEP:   state_next = (run_reg == '0) ? S_HRD : S_SLEEP;
                    OP_TICK:    state_next = (cur_reg == NIL) ? S_HRD : S_TPROC;
                    OP_PROMOTE: state_next = (ready_reg == NIL) ? S_HRD : S_PPROC;
                    default:    state_next = S_HRD;
                endcase
            end
            S_SLEEP:
            begin
                state_next = S_HRD;
            end
            S_TPROC:
            begin
                if (wake && prev_reg != NIL)
                begin
                    state_next = S_TFIX;
                end
                else if (r_link == NIL)
                begin
                    state_next = S_HRD;
                end
            end
            S_TFIX:
            begin
                state_next = (cur_reg == NIL) ? S_HRD : S_TPROC;
            end
            S_PPROC:
            begin
                if (r_link == NIL)
                begin
                    state_next = S_HRD;
                end
            end
            S_HRD:   state_next = S_HWAIT;
            S_HWAIT: state_next = S_OUT;
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next     = op_reg;
        pd_next     = pd_reg;
        st_next     = st_reg;
        free_next   = free_reg;
        ready_next  = ready_reg;
        run_next    = run_reg;
        sleep_next  = sleep_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        prec_next   = prec_reg;
        ctr_next    = ctr_reg;
        woken_next  = woken_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        tid_next    = tid_reg;
        rslot_next  = rslot_reg;
        rid_next    = rid_reg;
        rpd_next    = rpd_reg;
        idle_next   = idle_reg;
        we          = 1'b0;
        waddr       = cur_reg[SW-1:0];
        wdata       = rdata;
        raddr       = cur_reg[SW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                // take the beat and clear the result fields
                if (item_valid)
                begin
                    op_next     = operation;
                    pd_next     = page_dir;
                    st_next     = sleep_ticks;
                    cur_next    = sleep_reg;
                    prev_next   = NIL;
                    woken_next  = '0;
                    status_next = STAT_OK;
                    slot_next   = '0;
                    tid_next    = '0;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_ALLOC:
                    begin
                        if (free_reg == NIL)
                        begin
                            status_next = STAT_NO_FREE;
                        end
                        else
                        begin
                            we         = 1'b1;
                            waddr      = free_reg[SW-1:0];
                            wdata      = {ctr_reg + 32'd1, pd_reg, 32'd0, 32'd0, ready_reg};
                            ctr_next   = ctr_reg + 32'd1;
                            ready_next = free_reg;
                            free_next  = (free_reg == NIL - LW'(1)) ? NIL
                                                                     : free_reg + LW'(1);
                            slot_next  = free_reg;
                            tid_next   = ctr_reg + 32'd1;
                        end
                    end
                    OP_SLEEP:
                    begin
                        raddr = run_reg[SW-1:0];
                        if (run_reg == '0)
                        begin
                            status_next = STAT_IDLE;
                        end
                    end
                    OP_TICK:
                    begin
                        raddr = cur_reg[SW-1:0];
                    end
                    OP_PROMOTE:
                    begin
                        raddr = ready_reg[SW-1:0];
                    end
                    default:
                    begin
                        raddr = cur_reg[SW-1:0];
                    end
                endcase
            end
            S_SLEEP:
            begin
                // running head moves onto the sleeping list
                we         = 1'b1;
                waddr      = run_reg[SW-1:0];
                wdata      = {r_id, r_pd, 32'd0, st_reg, sleep_reg};
                sleep_next = run_reg;
                run_next   = r_link;
                slot_next  = run_reg;
                tid_next   = r_id;
            end
            S_TPROC:
            begin
                // one sleeping task per visit
                we       = 1'b1;
                waddr    = cur_reg[SW-1:0];
                raddr    = r_link[SW-1:0];
                cur_next = r_link;
                if (wake)
                begin
                    wdata      = {r_id, r_pd, cnt_inc, r_lim, ready_reg};
                    ready_next = cur_reg;
                    woken_next = woken_reg + 5'd1;
                    if (prev_reg == NIL)
                    begin
                        sleep_next = r_link;
                    end
                end
                else
                begin
                    wdata     = {r_id, r_pd, cnt_inc, r_lim, r_link};
                    prev_next = cur_reg;
                    prec_next = {r_id, r_pd, cnt_inc, r_lim, r_link};
                end
            end
            S_TFIX:
            begin
                // unlink the woken task behind its predecessor
                we        = 1'b1;
                waddr     = prev_reg[SW-1:0];
                wdata     = {prec_reg[RW-1:LW], cur_reg};
                prec_next = {prec_reg[RW-1:LW], cur_reg};
                raddr     = cur_reg[SW-1:0];
            end
            S_PPROC:
            begin
                // pop ready head, push onto running list
                we         = 1'b1;
                waddr      = ready_reg[SW-1:0];
                wdata      = {rdata[RW-1:LW], run_reg};
                run_next   = ready_reg;
                ready_next = r_link;
                raddr      = r_link[SW-1:0];
            end
            S_HRD:
            begin
                raddr = run_reg[SW-1:0];
            end
            S_HWAIT:
            begin
                // idle slot record is never written; its id and page dir are reported as zero
                rslot_next = 4'(run_reg);
                idle_next  = (run_reg == '0);
                rid_next   = (run_reg == '0) ? 32'd0 : r_id;
                rpd_next   = (run_reg == '0) ? 32'd0 : r_pd;
            end
            S_OUT:
            begin
                raddr = run_reg[SW-1:0];
            end
            default:
            begin
                raddr = cur_reg[SW-1:0];
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg  <= LW'(1);
            ready_reg <= NIL;
            run_reg   <= '0;
            sleep_reg <= NIL;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            ready_reg <= ready_next;
            run_reg   <= run_next;
            sleep_reg <= sleep_next;
            ctr_reg   <= ctr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pd_reg     <= pd_next;
        st_reg     <= st_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        prec_reg   <= prec_next;
        woken_reg  <= woken_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        tid_reg    <= tid_next;
        rslot_reg  <= rslot_next;
        rid_reg    <= rid_next;
        rpd_reg    <= rpd_next;
        idle_reg   <= idle_next;
    end

    assign item_stall       = (state_reg != S_IDLE);
    assign result_valid     = (state_reg == S_OUT);
    assign status           = status_reg;
    assign slot             = 4'(slot_reg);
    assign task_id          = tid_reg;
    assign running_slot     = rslot_reg;
    assign running_id       = rid_reg;
    assign running_page_dir = rpd_reg;
    assign woken_count      = woken_reg;
    assign idle             = idle_reg;

    // running list always ends in the idle slot, so its head is never null
    a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg != NIL)
        else $error("running head is null");

    // the idle slot never reaches the ready or sleeping lists
    a_idle_lists: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg != '0 && sleep_reg != '0)
        else $error("idle slot left the running list");

    // free pointer only moves forward within the table
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg != '0 && free_reg <= NIL)
        else $error("free pointer out of range");

    // an accepted beat always starts execution next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> state_reg == S_EXEC)
        else $error("accepted beat not executed");

    // result only offered while no input is taken
    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input open while result pending");

endmodule
